// File: rtl/wspcm_pkg.sv
`timescale 1ns / 1ps

package wspcm_pkg;

	// sample format codes
	typedef enum logic [1:0] {
		FMT_PCM   = 2'd0,
		FMT_FLOAT = 2'd1,
		FMT_ALAW  = 2'd2,
		FMT_ULAW  = 2'd3
	} fmt_t;

	// configuration register indexes
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 7;
	localparam logic [CFG_IDX_W-1:0] REG_FORMAT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BITS   = 1'd1;

	// sample widths
	localparam int BITS_W = 7;
	localparam logic [BITS_W-1:0] BITS_8      = 7'd8;
	localparam logic [BITS_W-1:0] BITS_12     = 7'd12;
	localparam logic [BITS_W-1:0] BITS_16     = 7'd16;
	localparam logic [BITS_W-1:0] BITS_24     = 7'd24;
	localparam logic [BITS_W-1:0] BITS_32     = 7'd32;
	localparam logic [BITS_W-1:0] BITS_64     = 7'd64;
	localparam logic [BITS_W-1:0] BITS_RESET  = BITS_16;

	localparam int RAW_W = 64;
	localparam int PCM_W = 16;

	// float scaling
	localparam logic [PCM_W-1:0] FULL_SCALE = 16'd32767;
	localparam int MANT_W = 53;
	localparam int PROD_W = MANT_W + 15;

endpackage

// File: rtl/wspcm_float_scale.sv
`timescale 1ns / 1ps

module wspcm_float_scale (
	input  logic [wspcm_pkg::RAW_W-1:0] raw,
	input  logic                        is_double,
	output logic [wspcm_pkg::PCM_W-1:0] result
);
	import wspcm_pkg::*;

	logic              sign;
	logic              is_zero;
	logic              is_sat;
	logic [MANT_W-1:0] mant;
	logic [10:0]       shift;
	logic [PROD_W-1:0] prod;
	logic [PROD_W-1:0] shifted;
	logic [PCM_W-1:0]  mag;

	// unpack both precisions onto one 53-bit mantissa and right shift
	always_comb begin
		if (is_double) begin
			sign    = raw[63];
			is_zero = (raw[62:52] == 11'd0);
			is_sat  = (raw[62:52] >= 11'd1023);
			mant    = {1'b1, raw[51:0]};
			shift   = 11'd1075 - raw[62:52];
		end else begin
			sign    = raw[31];
			is_zero = (raw[30:23] == 8'd0);
			is_sat  = (raw[30:23] >= 8'd127);
			mant    = {1'b1, raw[22:0], 29'd0};
			shift   = 11'd179 - {3'd0, raw[30:23]};
		end
	end

	// times 32767 as (m << 15) - m, then floor by the exponent shift
	assign prod    = (PROD_W'(mant) << 15) - PROD_W'(mant);
	assign shifted = prod >> shift[6:0];

	always_comb begin
		if (is_zero) begin
			mag = '0;
		end else if (is_sat) begin
			mag = FULL_SCALE;
		end else if (shift >= 11'(PROD_W)) begin
			mag = '0;
		end else begin
			mag = shifted[PCM_W-1:0];
		end
	end

	assign result = sign ? (PCM_W'(0) - mag) : mag;

endmodule

// File: rtl/wspcm_law_expand.sv
`timescale 1ns / 1ps

module wspcm_law_expand (
	input  logic [7:0]                  code,
	input  logic                        is_mu,
	output logic [wspcm_pkg::PCM_W-1:0] result
);
	import wspcm_pkg::*;

	logic [7:0]       av;
	logic [7:0]       uv;
	logic [PCM_W-1:0] a_mag;
	logic [PCM_W-1:0] u_mag;
	logic [PCM_W-1:0] a_res;
	logic [PCM_W-1:0] u_res;
	logic [2:0]       a_seg;

	// a-law: even bits inverted, segment 0 is linear
	assign av    = code ^ 8'h55;
	assign a_seg = av[6:4];

	always_comb begin
		if (a_seg == 3'd0) begin
			a_mag = PCM_W'({av[3:0], 4'd0}) + PCM_W'(8);
		end else begin
			a_mag = (PCM_W'({av[3:0], 4'd0}) + PCM_W'(16'h108)) << (a_seg - 3'd1);
		end
	end

	assign a_res = av[7] ? a_mag : (PCM_W'(0) - a_mag);

	// mu-law: all bits inverted, bias of 0x84 removed after the shift
	assign uv    = ~code;
	assign u_mag = (PCM_W'({uv[3:0], 3'd0}) + PCM_W'(16'h84)) << uv[6:4];
	assign u_res = uv[7] ? (PCM_W'(16'h84) - u_mag) : (u_mag - PCM_W'(16'h84));

	assign result = is_mu ? u_res : a_res;

endmodule

// File: rtl/wave_sample_to_pcm16_unit.sv
`timescale 1ns / 1ps
// wave_sample_to_pcm16_unit
// Converts one raw little-endian audio sample per request into a signed
// 16-bit sample. Integer pcm is narrowed to its top 16 bits (8-bit pcm is
// zero-extended), ieee float is clamped and scaled by 32767, a-law and
// mu-law bytes are expanded. Input channel: in_valid / in_stall with
// raw_sample. Output channel: out_valid / out_stall with pcm_out and
// bad_mode (set, zero output, for an unsupported format/width pair).
// Configuration: cfg_we with cfg_index (0 format, 1 bits) and cfg_wdata;
// write only while no request is in flight.
// Pipeline: a request accepted into the input register is converted and
// shown on the output from the result register. Throughput is one
// request per cycle while out_stall is low, set by the input register and
// the result register with one conversion pass between them.
// Reset clears both pipeline valids and loads format 0 (pcm), bits 16.
// When the receiver stalls, the result register holds; the input register
// still takes one more request, and in_stall rises only when both
// registers are full and out_stall is high.
module wave_sample_to_pcm16_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [wspcm_pkg::RAW_W-1:0]      raw_sample,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [wspcm_pkg::PCM_W-1:0] pcm_out,
	output logic                             bad_mode,
	input  logic                             cfg_we,
	input  logic [wspcm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wspcm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import wspcm_pkg::*;

	fmt_t              format_q;
	logic [BITS_W-1:0] bits_q;

	logic              valid_s1;
	logic [RAW_W-1:0]  raw_s1;
	logic              valid_s2;
	logic [PCM_W-1:0]  pcm_s2;
	logic              bad_s2;

	logic              en_s1;
	logic              en_s2;
	logic [PCM_W-1:0]  float_res;
	logic [PCM_W-1:0]  law_res;
	logic [PCM_W-1:0]  conv_res;
	logic              conv_bad;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			format_q <= FMT_PCM;
			bits_q   <= BITS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FORMAT: format_q <= fmt_t'(cfg_wdata[1:0]);
				REG_BITS:   bits_q   <= cfg_wdata;
				default:    ;
			endcase
		end
	end

	// pipeline enables
	assign en_s2    = !valid_s2 || !out_stall;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_stall = !en_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			raw_s1 <= raw_sample;
		end
	end

	// conversion units
	wspcm_float_scale u_float (
		.raw       (raw_s1),
		.is_double (bits_q == BITS_64),
		.result    (float_res)
	);

	wspcm_law_expand u_law (
		.code   (raw_s1[7:0]),
		.is_mu  (format_q == FMT_ULAW),
		.result (law_res)
	);

	// select by format and width
	always_comb begin
		conv_res = '0;
		conv_bad = 1'b0;
		unique case (format_q)
			FMT_PCM: begin
				if (bits_q == BITS_8) begin
					conv_res = PCM_W'(raw_s1[7:0]);
				end else if (bits_q == BITS_12 || bits_q == BITS_16) begin
					conv_res = raw_s1[15:0];
				end else if (bits_q == BITS_24) begin
					conv_res = raw_s1[23:8];
				end else if (bits_q == BITS_32) begin
					conv_res = raw_s1[31:16];
				end else begin
					conv_bad = 1'b1;
				end
			end
			FMT_FLOAT: begin
				if (bits_q == BITS_32 || bits_q == BITS_64) begin
					conv_res = float_res;
				end else begin
					conv_bad = 1'b1;
				end
			end
			FMT_ALAW, FMT_ULAW: begin
				if (bits_q == BITS_8) begin
					conv_res = law_res;
				end else begin
					conv_bad = 1'b1;
				end
			end
			default: conv_bad = 1'b1;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && valid_s1) begin
			pcm_s2 <= conv_res;
			bad_s2 <= conv_bad;
		end
	end

	assign out_valid = valid_s2;
	assign pcm_out   = signed'(pcm_s2);
	assign bad_mode  = bad_s2;

endmodule

// File: rtl/wspcm_checker.sv
`timescale 1ns / 1ps

module wspcm_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_stall,
	input logic                               out_valid,
	input logic                               out_stall,
	input logic signed [wspcm_pkg::PCM_W-1:0] pcm_out,
	input logic                               bad_mode
);
	import wspcm_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pcm_out) && $stable(bad_mode))
		else $error("stalled result changed");

	// unsupported mode always gives zero
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_mode |-> pcm_out == '0)
		else $error("bad mode with nonzero sample");

	// input back-pressure only when the output is blocked
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output stall");

	// a fresh result comes from an accepted request
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result without request");

endmodule

bind wave_sample_to_pcm16_unit wspcm_checker u_wspcm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.pcm_out   (pcm_out),
	.bad_mode  (bad_mode)
);
